// ===== rtl/bcc_pkg.sv =====
// Shared types, register indexes, event codes and reset values of the button click classifier.
package bcc_pkg;

  localparam int unsigned TimerW  = 16;
  localparam int unsigned TickW   = 8;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDatW = 16;
  localparam int unsigned EventW  = 3;

  localparam logic [TimerW-1:0] TimerMax = {TimerW{1'b1}};

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegMinDown   = 4'd0;
  localparam logic [CfgIdxW-1:0] RegLongpress = 4'd1;
  localparam logic [CfgIdxW-1:0] RegUpSettle  = 4'd2;
  localparam logic [CfgIdxW-1:0] RegDcGrace   = 4'd3;
  localparam logic [CfgIdxW-1:0] RegRepeat    = 4'd4;
  localparam logic [CfgIdxW-1:0] RegDcEnable  = 4'd5;
  localparam logic [CfgIdxW-1:0] RegActHigh   = 4'd6;
  localparam logic [CfgIdxW-1:0] RegTick      = 4'd7;

  // Reset values of the configuration registers.
  localparam logic [TimerW-1:0] RstMinDown   = 16'd20;
  localparam logic [TimerW-1:0] RstLongpress = 16'd300;
  localparam logic [TimerW-1:0] RstUpSettle  = 16'd20;
  localparam logic [TimerW-1:0] RstDcGrace   = 16'd120;
  localparam logic [TimerW-1:0] RstRepeat    = 16'd0;
  localparam logic              RstDcEnable  = 1'b1;
  localparam logic              RstActHigh   = 1'b0;
  localparam logic [TickW-1:0]  RstTick      = 8'd10;

  // Input command codes.
  localparam logic CmdEdge = 1'b0;
  localparam logic CmdTick = 1'b1;

  // Event codes on the result channel.
  localparam logic [EventW-1:0] EvDown      = 3'd0;
  localparam logic [EventW-1:0] EvUp        = 3'd1;
  localparam logic [EventW-1:0] EvClick     = 3'd2;
  localparam logic [EventW-1:0] EvDouble    = 3'd3;
  localparam logic [EventW-1:0] EvLong      = 3'd4;
  localparam logic [EventW-1:0] EvStilldown = 3'd5;

  typedef enum logic [2:0] {
    PhIdle    = 3'd0,
    PhQual    = 3'd1,
    PhHold    = 3'd2,
    PhSettle1 = 3'd3,
    PhWaitDc  = 3'd4,
    PhQual2   = 3'd5,
    PhWaitUp  = 3'd6,
    PhSettle2 = 3'd7
  } phase_e;

  typedef struct packed {
    logic [TimerW-1:0] min_down_ms;
    logic [TimerW-1:0] longpress_ms;
    logic [TimerW-1:0] up_settle_ms;
    logic [TimerW-1:0] doubleclick_grace_ms;
    logic [TimerW-1:0] repeat_down_ms;
    logic              doubleclick_enable;
    logic              active_high;
    logic [TickW-1:0]  tick_ms;
  } cfg_t;

  // One item handed from the input register to the classifier.
  typedef struct packed {
    logic valid;
    logic cmd;
    logic pin_level;
  } item_t;

  // Classifier verdict for one item.
  typedef struct packed {
    logic              valid;
    logic [EventW-1:0] code;
  } event_t;

endpackage

// ===== rtl/bcc_cfg.sv =====
// Configuration register file of the button click classifier.
module bcc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [bcc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bcc_pkg::CfgDatW-1:0]   cfg_data_i,
  output bcc_pkg::cfg_t                 cfg_o
);

  bcc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        bcc_pkg::RegMinDown:   cfg_d.min_down_ms          = cfg_data_i;
        bcc_pkg::RegLongpress: cfg_d.longpress_ms         = cfg_data_i;
        bcc_pkg::RegUpSettle:  cfg_d.up_settle_ms         = cfg_data_i;
        bcc_pkg::RegDcGrace:   cfg_d.doubleclick_grace_ms = cfg_data_i;
        bcc_pkg::RegRepeat:    cfg_d.repeat_down_ms       = cfg_data_i;
        bcc_pkg::RegDcEnable:  cfg_d.doubleclick_enable   = cfg_data_i[0];
        bcc_pkg::RegActHigh:   cfg_d.active_high          = cfg_data_i[0];
        bcc_pkg::RegTick:      cfg_d.tick_ms              = cfg_data_i[bcc_pkg::TickW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_down_ms          <= bcc_pkg::RstMinDown;
      cfg_q.longpress_ms         <= bcc_pkg::RstLongpress;
      cfg_q.up_settle_ms         <= bcc_pkg::RstUpSettle;
      cfg_q.doubleclick_grace_ms <= bcc_pkg::RstDcGrace;
      cfg_q.repeat_down_ms       <= bcc_pkg::RstRepeat;
      cfg_q.doubleclick_enable   <= bcc_pkg::RstDcEnable;
      cfg_q.active_high          <= bcc_pkg::RstActHigh;
      cfg_q.tick_ms              <= bcc_pkg::RstTick;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/bcc_fsm.sv =====
// Phase machine and age/repeat timers that classify one item per cycle.
module bcc_fsm (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bcc_pkg::cfg_t   cfg_i,
  input  bcc_pkg::item_t  item_i,
  output bcc_pkg::event_t event_o
);

  localparam int unsigned W = bcc_pkg::TimerW;

  bcc_pkg::phase_e phase_q, phase_d;
  logic [W-1:0]    age_q, age_d;
  logic [W-1:0]    rep_q, rep_d;

  logic [W:0]   age_sum, rep_sum;
  logic [W-1:0] age_sat, rep_sat;
  logic         is_tick, is_edge, active, rep_due;
  logic         age_ge_min, age_eq_min, age_ge_long, age_gt_settle, age_ge_settle, age_ge_grace;

  assign is_tick = item_i.valid && (item_i.cmd == bcc_pkg::CmdTick) && (phase_q != bcc_pkg::PhIdle);
  assign is_edge = item_i.valid && (item_i.cmd == bcc_pkg::CmdEdge) && (phase_q == bcc_pkg::PhIdle);

  assign age_sum = {1'b0, age_q} + {{(W + 1 - bcc_pkg::TickW){1'b0}}, cfg_i.tick_ms};
  assign rep_sum = {1'b0, rep_q} + {{(W + 1 - bcc_pkg::TickW){1'b0}}, cfg_i.tick_ms};
  assign age_sat = age_sum[W] ? bcc_pkg::TimerMax : age_sum[W-1:0];
  assign rep_sat = rep_sum[W] ? bcc_pkg::TimerMax : rep_sum[W-1:0];

  assign active        = (item_i.pin_level == cfg_i.active_high);
  assign rep_due       = (cfg_i.repeat_down_ms != '0) && (rep_sat > cfg_i.repeat_down_ms);
  assign age_ge_min    = (age_sat >= cfg_i.min_down_ms);
  assign age_eq_min    = (age_sat == cfg_i.min_down_ms);
  assign age_ge_long   = (age_sat >= cfg_i.longpress_ms);
  assign age_gt_settle = (age_sat > cfg_i.up_settle_ms);
  assign age_ge_settle = (age_sat >= cfg_i.up_settle_ms);
  assign age_ge_grace  = (age_sat >= cfg_i.doubleclick_grace_ms);

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (is_edge) begin
      phase_d = bcc_pkg::PhQual;
    end else if (is_tick) begin
      case (phase_q)
        bcc_pkg::PhQual: begin
          if (!active)         phase_d = bcc_pkg::PhSettle2;
          else if (age_ge_min) phase_d = bcc_pkg::PhHold;
        end
        bcc_pkg::PhHold: begin
          if (age_ge_long) phase_d = bcc_pkg::PhWaitUp;
          else if (!active) begin
            phase_d = cfg_i.doubleclick_enable ? bcc_pkg::PhSettle1 : bcc_pkg::PhSettle2;
          end
        end
        bcc_pkg::PhSettle1: begin
          if (age_gt_settle) phase_d = bcc_pkg::PhWaitDc;
        end
        bcc_pkg::PhWaitDc: begin
          if (active)            phase_d = bcc_pkg::PhQual2;
          else if (age_ge_grace) phase_d = bcc_pkg::PhSettle2;
        end
        bcc_pkg::PhQual2: begin
          if (!active)                       phase_d = bcc_pkg::PhSettle2;
          else if (!age_eq_min && age_ge_min) phase_d = bcc_pkg::PhWaitUp;
        end
        bcc_pkg::PhWaitUp: begin
          if (!active) phase_d = bcc_pkg::PhSettle2;
        end
        bcc_pkg::PhSettle2: begin
          if (age_ge_settle) phase_d = bcc_pkg::PhIdle;
        end
        default: ;
      endcase
    end
  end

  // Timers and the event for this item.
  always_comb begin
    age_d         = age_q;
    rep_d         = rep_q;
    event_o.valid = 1'b0;
    event_o.code  = bcc_pkg::EvDown;
    if (is_edge) begin
      age_d = '0;
    end else if (is_tick) begin
      age_d = age_sat;
      rep_d = rep_sat;
      case (phase_q)
        bcc_pkg::PhQual: begin
          if (!active) begin
            age_d = '0;
          end else if (age_ge_min) begin
            rep_d         = '0;
            event_o.valid = 1'b1;
            event_o.code  = bcc_pkg::EvDown;
          end
        end
        bcc_pkg::PhHold: begin
          if (age_ge_long) begin
            event_o.valid = 1'b1;
            event_o.code  = bcc_pkg::EvLong;
          end else if (!active) begin
            age_d         = '0;
            event_o.valid = 1'b1;
            event_o.code  = cfg_i.doubleclick_enable ? bcc_pkg::EvUp : bcc_pkg::EvClick;
          end else if (rep_due) begin
            rep_d         = '0;
            event_o.valid = 1'b1;
            event_o.code  = bcc_pkg::EvStilldown;
          end
        end
        bcc_pkg::PhWaitDc: begin
          if (active) begin
            age_d = '0;
          end else if (age_ge_grace) begin
            age_d         = '0;
            event_o.valid = 1'b1;
            event_o.code  = bcc_pkg::EvClick;
          end
        end
        bcc_pkg::PhQual2: begin
          if (!active) begin
            age_d         = '0;
            event_o.valid = 1'b1;
            event_o.code  = bcc_pkg::EvClick;
          end else if (age_eq_min) begin
            event_o.valid = 1'b1;
            event_o.code  = bcc_pkg::EvDown;
          end else if (age_ge_min) begin
            event_o.valid = 1'b1;
            event_o.code  = bcc_pkg::EvDouble;
          end
        end
        bcc_pkg::PhWaitUp: begin
          if (!active) begin
            age_d         = '0;
            event_o.valid = 1'b1;
            event_o.code  = bcc_pkg::EvUp;
          end else if (rep_due) begin
            rep_d         = '0;
            event_o.valid = 1'b1;
            event_o.code  = bcc_pkg::EvStilldown;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bcc_pkg::PhIdle;
      age_q   <= '0;
      rep_q   <= '0;
    end else begin
      phase_q <= phase_d;
      age_q   <= age_d;
      rep_q   <= rep_d;
    end
  end

endmodule

// ===== rtl/button_click_classifier_top.sv =====
// Top level of the button click classifier: input register, classifier and result register.
//
// One instance serves one push button. The input channel (in_valid_i/in_ready_o) carries
// beats of cmd_i (edge event or monitor tick) and pin_level_i. The result channel
// (out_valid_o/out_ready_i) carries event_code_o: down, up, click, doubleclick,
// longclick or stilldown. An input beat gives zero or one result beat.
//
// Each accepted beat is held in an input register and classified once the result register
// is free or being emptied. Its event, if any, is loaded into the result register at the
// end of that cycle, so out_valid_o comes from the result register, behind the input
// register. One beat is taken per cycle as long as the result register drains; the phase
// and timer registers are the only loop, with their next values computed combinationally.
// When the receiver stalls with a result pending, the pending input beat waits in the
// input register and in_ready_o drops until the result is taken.
//
// The configuration channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i) is always
// ready; writes to indexes beyond the register list are dropped. Reset loads the default
// register values, sets the machine idle with both timers at zero and empties both
// registers of the data path.
module button_click_classifier_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bcc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [bcc_pkg::CfgDatW-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        cmd_i,
  input  logic                        pin_level_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bcc_pkg::EventW-1:0]  event_code_o
);

  bcc_pkg::cfg_t   cfg;
  bcc_pkg::item_t  item_q, item_d, item_fire;
  bcc_pkg::event_t evt;

  logic                       advance;
  logic                       out_valid_q, out_valid_d;
  logic [bcc_pkg::EventW-1:0] code_q, code_d;

  assign cfg_ready_o = 1'b1;

  bcc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // The held beat moves on when the result register is free or being emptied.
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !item_q.valid || advance;

  always_comb begin
    item_d = item_q;
    if (in_ready_o) begin
      item_d.valid     = in_valid_i;
      item_d.cmd       = cmd_i;
      item_d.pin_level = pin_level_i;
    end
  end

  always_comb begin
    item_fire       = item_q;
    item_fire.valid = item_q.valid && advance;
  end

  bcc_fsm u_fsm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .item_i  (item_fire),
    .event_o (evt)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    code_d      = code_q;
    if (advance) begin
      out_valid_d = evt.valid;
      code_d      = evt.code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      item_q      <= item_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
  end

  assign out_valid_o  = out_valid_q;
  assign event_code_o = code_q;

endmodule

// ===== rtl/bcc_checker.sv =====
// Port-level checker of the button click classifier and its bind to the top level.
module bcc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [bcc_pkg::EventW-1:0]  event_code_o
);

  // A stalled result beat keeps its code.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(event_code_o)))
    else $error("result beat changed while stalled");

  a_code_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (event_code_o == bcc_pkg::EvDown || event_code_o == bcc_pkg::EvUp ||
                     event_code_o == bcc_pkg::EvClick || event_code_o == bcc_pkg::EvDouble ||
                     event_code_o == bcc_pkg::EvLong || event_code_o == bcc_pkg::EvStilldown))
    else $error("illegal event code");

  // With no result pending, the input side never blocks.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  // A new result follows an input beat that passed through the input register and the result register.
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without a matching input beat");

endmodule

bind button_click_classifier_top bcc_checker u_bcc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .event_code_o (event_code_o)
);
